>>> rtl/fbhp_pkg.sv
// Package for the bit file header parser.
// Holds the result kind and error code types and the header constants.
// No dependencies.
package fbhp_pkg;

   typedef enum logic [2:0] {
      KIND_STR_A = 3'd0,
      KIND_STR_B = 3'd1,
      KIND_STR_C = 3'd2,
      KIND_STR_D = 3'd3,
      KIND_DONE  = 3'd4,
      KIND_ERROR = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      ERR_NONE           = 4'd0,
      ERR_SIZE_SMALL     = 4'd1,
      ERR_MAGIC_OVERFLOW = 4'd2,
      ERR_EVEN_BYTE      = 4'd3,
      ERR_ODD_BYTE       = 4'd4,
      ERR_END_ROOM       = 4'd5,
      ERR_END_NONZERO    = 4'd6,
      ERR_NOT_ONE        = 4'd7,
      ERR_STRING_A       = 4'd8,
      ERR_STRING_B       = 4'd9,
      ERR_STRING_C       = 4'd10,
      ERR_STRING_D       = 4'd11,
      ERR_NO_ROOM_LENGTH = 4'd12,
      ERR_BAD_E          = 4'd13
   } err_type;

   localparam logic [7:0]  MAGIC_EVEN    = 8'h0f;
   localparam logic [7:0]  MAGIC_ODD     = 8'hf0;
   localparam logic [15:0] HALF_WORD_ONE = 16'h0001;
   localparam logic [7:0]  TAG_A         = 8'h61;
   localparam logic [7:0]  TAG_E         = 8'h65;

endpackage

>>> rtl/fbhp_req_if.sv
// Request channel interface for the bit file header parser: one header byte.
// Plain valid/ready handshake; no package dependency.
interface fbhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

>>> rtl/fbhp_rsp_if.sv
// Response channel interface for the bit file header parser.
// Uses the kind and error types from fbhp_pkg.
interface fbhp_rsp_if;
   logic               valid;
   logic               ready;
   fbhp_pkg::kind_type result_kind;
   logic [31:0]        str_offset;
   logic [15:0]        str_length;
   logic [31:0]        stream_size;
   logic [31:0]        header_size;
   logic [15:0]        magic_size;
   fbhp_pkg::err_type  error_code;

   modport source (output valid, output result_kind, output str_offset,
                   output str_length, output stream_size,
                   output header_size, output magic_size,
                   output error_code, input ready);
   modport sink (input valid, input result_kind, input str_offset,
                 input str_length, input stream_size,
                 input header_size, input magic_size,
                 input error_code, output ready);
endinterface

>>> rtl/fpga_bitfile_header_parser.sv
// Top level of the bit file header parser.
// Depends on fbhp_pkg, fbhp_req_if and fbhp_rsp_if.
//
// Usage. Header bytes arrive one per transaction on the req_if channel, in
// file order. The parser walks the header (magic length, magic pattern,
// zero byte, half word one, strings a to d, tag e and the bitstream length)
// and gives at most one result transaction per byte on rsp_if: one for each
// string found, then either a completion result or an error result, after
// which it rearms and the next byte starts a new header.
// The buffer size register is written through csr_wr_en/csr_wr_data; the
// user must do so only while the parser is idle, which the block does not
// enforce. Every bounds check compares a byte offset against it.
// Timing. Each accepted byte updates the parse state in the same clock and,
// if it completes a result, loads the result register, so the result is on
// rsp_if in the next cycle. One byte is taken every cycle unless stalled.
// Stalls. The result register is a one-deep output stage: a new byte is
// accepted while it is empty or while its content is taken in the same
// cycle. When the receiver holds ready low with a result waiting, the
// parser stops taking bytes until that result is taken.
// Reset. A synchronous reset clears the buffer size to zero, rearms the
// parser and drops any result that was waiting.
module fpga_bitfile_header_parser (
   input  logic                clock,
   input  logic                reset,
   fbhp_req_if.sink            req_if,
   fbhp_rsp_if.source          rsp_if,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data
);

   typedef enum logic [3:0] {
      PH_MLEN_HI   = 4'd0,
      PH_MLEN_LO   = 4'd1,
      PH_MAGIC     = 4'd2,
      PH_MAGIC_END = 4'd3,
      PH_HW_HI     = 4'd4,
      PH_HW_LO     = 4'd5,
      PH_TAG       = 4'd6,
      PH_SLEN_HI   = 4'd7,
      PH_SLEN_LO   = 4'd8,
      PH_TEXT      = 4'd9,
      PH_ETAG      = 4'd10,
      PH_BLEN      = 4'd11
   } phase_type;

   // Parse state.
   phase_type   phase_ff, phase_in;
   logic [31:0] byte_offset_ff, byte_offset_in;
   logic [15:0] field_remaining_ff, field_remaining_in;
   logic [31:0] length_acc_ff, length_acc_in;
   logic [1:0]  string_index_ff, string_index_in;
   logic [7:0]  previous_byte_ff, previous_byte_in;
   logic [15:0] saved_magic_ff, saved_magic_in;
   logic [31:0] buffer_size_ff;

   // Result register.
   logic                rsp_valid_ff;
   fbhp_pkg::kind_type  rsp_kind_ff;
   logic [31:0]         rsp_offset_ff;
   logic [15:0]         rsp_length_ff;
   logic [31:0]         rsp_blen_ff;
   logic [31:0]         rsp_hlen_ff;
   logic [15:0]         rsp_magic_ff;
   fbhp_pkg::err_type   rsp_err_ff;

   // Result computed for the byte being accepted.
   logic                emit;
   logic                rearm;
   fbhp_pkg::kind_type  res_kind;
   logic [31:0]         res_offset;
   logic [15:0]         res_length;
   logic [31:0]         res_blen;
   logic [31:0]         res_hlen;
   logic [15:0]         res_magic;
   fbhp_pkg::err_type   res_err;

   logic        req_fire;
   logic [7:0]  data_byte;
   logic [32:0] next_wide;
   logic [31:0] next_offset;
   logic [15:0] pair_word;
   logic [33:0] pair_end;
   logic [32:0] here_plus3;
   logic [32:0] here_plus5;
   logic [31:0] shifted_acc;
   logic [15:0] remaining_dec;

   // A byte is taken whenever the result register is free or being emptied.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign data_byte    = req_if.data_byte;

   // Offsets and bounds sums; the bounds sums are kept wide so none of them wraps.
   assign next_wide     = {1'b0, byte_offset_ff} + 33'd1;
   assign next_offset   = byte_offset_ff + 32'd1;
   assign pair_word     = {previous_byte_ff, data_byte};
   assign pair_end      = {1'b0, next_wide} + {18'd0, pair_word};
   assign here_plus3    = {1'b0, byte_offset_ff} + 33'd3;
   assign here_plus5    = {1'b0, byte_offset_ff} + 33'd5;
   assign shifted_acc   = {length_acc_ff[23:0], data_byte};
   assign remaining_dec = field_remaining_ff - 16'd1;

   always_comb begin
      phase_in           = phase_ff;
      byte_offset_in     = next_offset;
      field_remaining_in = field_remaining_ff;
      length_acc_in      = length_acc_ff;
      string_index_in    = string_index_ff;
      previous_byte_in   = previous_byte_ff;
      saved_magic_in     = saved_magic_ff;

      emit       = 1'b0;
      rearm      = 1'b0;
      res_kind   = fbhp_pkg::KIND_ERROR;
      res_offset = '0;
      res_length = '0;
      res_blen   = '0;
      res_hlen   = '0;
      res_magic  = saved_magic_ff;
      res_err    = fbhp_pkg::ERR_NONE;

      unique case (phase_ff)
         PH_MLEN_HI: begin
            if (buffer_size_ff < 32'd2) begin
               emit    = 1'b1;
               rearm   = 1'b1;
               res_err = fbhp_pkg::ERR_SIZE_SMALL;
            end else begin
               previous_byte_in = data_byte;
               phase_in         = PH_MLEN_LO;
            end
         end
         PH_MLEN_LO: begin
            // The error result carries the magic length just read.
            saved_magic_in = pair_word;
            res_magic      = pair_word;
            if (pair_end > {2'd0, buffer_size_ff}) begin
               emit    = 1'b1;
               rearm   = 1'b1;
               res_err = fbhp_pkg::ERR_MAGIC_OVERFLOW;
            end else if (pair_word <= 16'd1) begin
               phase_in = PH_MAGIC_END;
            end else begin
               field_remaining_in = pair_word - 16'd1;
               phase_in           = PH_MAGIC;
            end
         end
         PH_MAGIC: begin
            if (!byte_offset_ff[0] && data_byte != fbhp_pkg::MAGIC_EVEN) begin
               emit    = 1'b1;
               rearm   = 1'b1;
               res_err = fbhp_pkg::ERR_EVEN_BYTE;
            end else if (byte_offset_ff[0] && data_byte != fbhp_pkg::MAGIC_ODD) begin
               emit    = 1'b1;
               rearm   = 1'b1;
               res_err = fbhp_pkg::ERR_ODD_BYTE;
            end else begin
               field_remaining_in = remaining_dec;
               if (remaining_dec == 16'd0) begin
                  phase_in = PH_MAGIC_END;
               end
            end
         end
         PH_MAGIC_END: begin
            if (here_plus3 > {1'b0, buffer_size_ff}) begin
               emit    = 1'b1;
               rearm   = 1'b1;
               res_err = fbhp_pkg::ERR_END_ROOM;
            end else if (data_byte != 8'd0) begin
               emit    = 1'b1;
               rearm   = 1'b1;
               res_err = fbhp_pkg::ERR_END_NONZERO;
            end else begin
               phase_in = PH_HW_HI;
            end
         end
         PH_HW_HI: begin
            previous_byte_in = data_byte;
            phase_in         = PH_HW_LO;
         end
         PH_HW_LO: begin
            if (pair_word != fbhp_pkg::HALF_WORD_ONE) begin
               emit    = 1'b1;
               rearm   = 1'b1;
               res_err = fbhp_pkg::ERR_NOT_ONE;
            end else begin
               phase_in = PH_TAG;
            end
         end
         PH_TAG: begin
            if (here_plus3 > {1'b0, buffer_size_ff} ||
                data_byte != fbhp_pkg::TAG_A + {6'd0, string_index_ff}) begin
               emit    = 1'b1;
               rearm   = 1'b1;
               res_err = fbhp_pkg::err_type'(4'(fbhp_pkg::ERR_STRING_A)
                                             + {2'd0, string_index_ff});
            end else begin
               phase_in = PH_SLEN_HI;
            end
         end
         PH_SLEN_HI: begin
            previous_byte_in = data_byte;
            phase_in         = PH_SLEN_LO;
         end
         PH_SLEN_LO: begin
            length_acc_in = {16'd0, pair_word};
            if (pair_end > {2'd0, buffer_size_ff}) begin
               emit    = 1'b1;
               rearm   = 1'b1;
               res_err = fbhp_pkg::err_type'(4'(fbhp_pkg::ERR_STRING_A)
                                             + {2'd0, string_index_ff});
            end else if (pair_word == 16'd0) begin
               // An empty string is reported straight after its length.
               emit            = 1'b1;
               res_kind        = fbhp_pkg::kind_type'({1'b0, string_index_ff});
               res_offset      = next_offset;
               string_index_in = string_index_ff + 2'd1;
               phase_in        = (string_index_ff == 2'd3) ? PH_ETAG : PH_TAG;
            end else begin
               field_remaining_in = pair_word;
               phase_in           = PH_TEXT;
            end
         end
         PH_TEXT: begin
            field_remaining_in = remaining_dec;
            if (remaining_dec == 16'd0) begin
               // Last text byte must be the terminating NUL.
               emit = 1'b1;
               if (data_byte != 8'd0) begin
                  rearm   = 1'b1;
                  res_err = fbhp_pkg::err_type'(4'(fbhp_pkg::ERR_STRING_A)
                                                + {2'd0, string_index_ff});
               end else begin
                  res_kind        = fbhp_pkg::kind_type'({1'b0, string_index_ff});
                  res_offset      = next_offset - length_acc_ff;
                  res_length      = length_acc_ff[15:0];
                  string_index_in = string_index_ff + 2'd1;
                  phase_in        = (string_index_ff == 2'd3) ? PH_ETAG : PH_TAG;
               end
            end
         end
         PH_ETAG: begin
            if (here_plus5 >= {1'b0, buffer_size_ff}) begin
               emit    = 1'b1;
               rearm   = 1'b1;
               res_err = fbhp_pkg::ERR_NO_ROOM_LENGTH;
            end else if (data_byte != fbhp_pkg::TAG_E) begin
               emit    = 1'b1;
               rearm   = 1'b1;
               res_err = fbhp_pkg::ERR_BAD_E;
            end else begin
               field_remaining_in = 16'd4;
               length_acc_in      = '0;
               phase_in           = PH_BLEN;
            end
         end
         PH_BLEN: begin
            length_acc_in      = shifted_acc;
            field_remaining_in = remaining_dec;
            if (remaining_dec == 16'd0) begin
               emit     = 1'b1;
               rearm    = 1'b1;
               res_kind = fbhp_pkg::KIND_DONE;
               res_blen = shifted_acc;
               res_hlen = next_offset;
            end
         end
         default: begin
            rearm = 1'b1;
         end
      endcase

      // Completion and every error start a new header.
      if (rearm) begin
         phase_in           = PH_MLEN_HI;
         byte_offset_in     = '0;
         field_remaining_in = '0;
         length_acc_in      = '0;
         string_index_in    = '0;
         previous_byte_in   = '0;
         saved_magic_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_MLEN_HI;
         byte_offset_ff     <= '0;
         field_remaining_ff <= '0;
         length_acc_ff      <= '0;
         string_index_ff    <= '0;
         previous_byte_ff   <= '0;
         saved_magic_ff     <= '0;
         buffer_size_ff     <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            buffer_size_ff <= csr_wr_data;
         end
         if (req_fire) begin
            phase_ff           <= phase_in;
            byte_offset_ff     <= byte_offset_in;
            field_remaining_ff <= field_remaining_in;
            length_acc_ff      <= length_acc_in;
            string_index_ff    <= string_index_in;
            previous_byte_ff   <= previous_byte_in;
            saved_magic_ff     <= saved_magic_in;
         end
         if (req_fire && emit) begin
            rsp_valid_ff  <= 1'b1;
            rsp_kind_ff   <= res_kind;
            rsp_offset_ff <= res_offset;
            rsp_length_ff <= res_length;
            rsp_blen_ff   <= res_blen;
            rsp_hlen_ff   <= res_hlen;
            rsp_magic_ff  <= res_magic;
            rsp_err_ff    <= res_err;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.result_kind = rsp_kind_ff;
   assign rsp_if.str_offset  = rsp_offset_ff;
   assign rsp_if.str_length  = rsp_length_ff;
   assign rsp_if.stream_size = rsp_blen_ff;
   assign rsp_if.header_size = rsp_hlen_ff;
   assign rsp_if.magic_size  = rsp_magic_ff;
   assign rsp_if.error_code  = rsp_err_ff;

   // A completion or error result leaves the parser at the start of a header.
   a_rearm_after_end: assert property (@(posedge clock) disable iff (reset)
      (req_fire && emit && (res_kind == fbhp_pkg::KIND_DONE ||
                            res_kind == fbhp_pkg::KIND_ERROR))
      |=> (phase_ff == PH_MLEN_HI && byte_offset_ff == '0))
      else $error("parser did not rearm after a final result");

   // An error code is given exactly on error results.
   a_error_code_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_kind_ff == fbhp_pkg::KIND_ERROR) ==
                        (rsp_err_ff != fbhp_pkg::ERR_NONE)))
      else $error("error code disagrees with result kind");

   // While text is being consumed there is always text left.
   a_text_remaining: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TEXT) |-> (field_remaining_ff != '0))
      else $error("text phase with no bytes left");

   // Every string result moves on to the next string tag.
   a_string_advance: assert property (@(posedge clock) disable iff (reset)
      (req_fire && emit && (res_kind == fbhp_pkg::KIND_STR_A ||
                            res_kind == fbhp_pkg::KIND_STR_B ||
                            res_kind == fbhp_pkg::KIND_STR_C ||
                            res_kind == fbhp_pkg::KIND_STR_D))
      |=> (string_index_ff == $past(string_index_ff) + 2'd1))
      else $error("string index did not advance after a string result");

endmodule

>>> tb/fbhp_checker.sv
// Checker for the bit file header parser: watches both channels and the
// register port, predicts every result and compares it field by field.
// Depends on fbhp_pkg, fbhp_req_if and fbhp_rsp_if.
module fbhp_checker (
   input  logic        clock,
   input  logic        reset,
   fbhp_req_if         req_mon,
   fbhp_rsp_if         rsp_mon,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output int          pending_count,
   output int          error_count
);

   typedef enum logic [3:0] {
      PH_LEN_HI, PH_LEN_LO, PH_MAGIC, PH_ZERO, PH_ONE_HI, PH_ONE_LO,
      PH_TAG, PH_SLEN_HI, PH_SLEN_LO, PH_TEXT, PH_TAG_E, PH_BLEN
   } walk_phase_type;

   typedef struct {
      fbhp_pkg::kind_type kind;
      logic [31:0]        str_offset;
      logic [15:0]        str_length;
      logic [31:0]        bit_length;
      logic [31:0]        hdr_length;
      logic [15:0]        magic_len;
      fbhp_pkg::err_type  err;
   } header_event_type;

   logic [31:0]      buf_size;
   walk_phase_type   walk;
   logic [31:0]      offset;
   logic [15:0]      remaining;
   logic [31:0]      acc;
   logic [1:0]       str_idx;
   logic [7:0]       prev;
   logic [15:0]      magic_len;
   header_event_type header_events_due[$];
   header_event_type seen_ev;
   header_event_type want;
   int               mismatches = 0;

   function automatic void rearm();
      walk      = PH_LEN_HI;
      offset    = '0;
      remaining = '0;
      acc       = '0;
      str_idx   = '0;
      prev      = '0;
      magic_len = '0;
   endfunction

   function automatic header_event_type make_event(fbhp_pkg::kind_type kind,
                                                   logic [31:0] soff,
                                                   logic [15:0] slen,
                                                   logic [31:0] blen,
                                                   logic [31:0] hlen,
                                                   fbhp_pkg::err_type err);
      header_event_type ev;
      ev.kind       = kind;
      ev.str_offset = soff;
      ev.str_length = slen;
      ev.bit_length = blen;
      ev.hdr_length = hlen;
      ev.magic_len  = magic_len;
      ev.err        = err;
      return ev;
   endfunction

   // The error result carries the magic length read so far, so it is built
   // before the walk is rearmed.
   function automatic bit fault(fbhp_pkg::err_type code, output header_event_type ev);
      ev = make_event(fbhp_pkg::KIND_ERROR, '0, '0, '0, '0, code);
      rearm();
      return 1'b1;
   endfunction

   function automatic fbhp_pkg::err_type string_fault(logic [1:0] k);
      return fbhp_pkg::err_type'(fbhp_pkg::ERR_STRING_A + k);
   endfunction

   function automatic void next_string(logic [1:0] k);
      str_idx = k + 2'd1;
      walk    = (k == 2'd3) ? PH_TAG_E : PH_TAG;
   endfunction

   // One header byte in; returns 1 when it completes a result.
   function automatic bit predict_byte(input logic [7:0] b,
                                       output header_event_type ev);
      logic [32:0] here;
      logic [32:0] nxt;
      logic [32:0] room;
      logic [1:0]  k;
      here = {1'b0, offset};
      nxt  = here + 33'd1;
      room = {1'b0, buf_size};
      k    = str_idx;
      ev   = make_event(fbhp_pkg::KIND_DONE, '0, '0, '0, '0, fbhp_pkg::ERR_NONE);
      case (walk)
         PH_LEN_HI: begin
            if (room < 33'd2) return fault(fbhp_pkg::ERR_SIZE_SMALL, ev);
            prev = b;
            walk = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            magic_len = {prev, b};
            if (nxt + magic_len > room) return fault(fbhp_pkg::ERR_MAGIC_OVERFLOW, ev);
            if (magic_len <= 16'd1) begin
               walk = PH_ZERO;
            end else begin
               remaining = magic_len - 16'd1;
               walk      = PH_MAGIC;
            end
         end
         PH_MAGIC: begin
            if (!here[0]) begin
               if (b != fbhp_pkg::MAGIC_EVEN) return fault(fbhp_pkg::ERR_EVEN_BYTE, ev);
            end else if (b != fbhp_pkg::MAGIC_ODD) begin
               return fault(fbhp_pkg::ERR_ODD_BYTE, ev);
            end
            remaining = remaining - 16'd1;
            if (remaining == 16'd0) walk = PH_ZERO;
         end
         PH_ZERO: begin
            if (here + 33'd3 > room) return fault(fbhp_pkg::ERR_END_ROOM, ev);
            if (b != 8'd0) return fault(fbhp_pkg::ERR_END_NONZERO, ev);
            walk = PH_ONE_HI;
         end
         PH_ONE_HI: begin
            prev = b;
            walk = PH_ONE_LO;
         end
         PH_ONE_LO: begin
            if ({prev, b} != fbhp_pkg::HALF_WORD_ONE)
               return fault(fbhp_pkg::ERR_NOT_ONE, ev);
            walk = PH_TAG;
         end
         PH_TAG: begin
            if (here + 33'd3 > room || b != fbhp_pkg::TAG_A + k)
               return fault(string_fault(k), ev);
            walk = PH_SLEN_HI;
         end
         PH_SLEN_HI: begin
            prev = b;
            walk = PH_SLEN_LO;
         end
         PH_SLEN_LO: begin
            acc = {16'd0, prev, b};
            if (nxt + acc > room) return fault(string_fault(k), ev);
            if (acc == 32'd0) begin
               offset = nxt[31:0];
               ev = make_event(fbhp_pkg::kind_type'(k), offset, 16'd0, '0, '0,
                               fbhp_pkg::ERR_NONE);
               next_string(k);
               return 1'b1;
            end
            remaining = acc[15:0];
            walk      = PH_TEXT;
         end
         PH_TEXT: begin
            remaining = remaining - 16'd1;
            if (remaining == 16'd0) begin
               if (b != 8'd0) return fault(string_fault(k), ev);
               offset = nxt[31:0];
               ev = make_event(fbhp_pkg::kind_type'(k), offset - acc, acc[15:0],
                               '0, '0, fbhp_pkg::ERR_NONE);
               next_string(k);
               return 1'b1;
            end
         end
         PH_TAG_E: begin
            if (here + 33'd5 >= room) return fault(fbhp_pkg::ERR_NO_ROOM_LENGTH, ev);
            if (b != fbhp_pkg::TAG_E) return fault(fbhp_pkg::ERR_BAD_E, ev);
            remaining = 16'd4;
            acc       = '0;
            walk      = PH_BLEN;
         end
         default: begin
            acc       = {acc[23:0], b};
            remaining = remaining - 16'd1;
            if (remaining == 16'd0) begin
               ev = make_event(fbhp_pkg::KIND_DONE, '0, '0, acc, nxt[31:0],
                               fbhp_pkg::ERR_NONE);
               rearm();
               return 1'b1;
            end
         end
      endcase
      offset = nxt[31:0];
      return 1'b0;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
      mismatches++;
      if (mismatches <= 50)
         $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, exp);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] exp);
      if (got !== exp) report(what, got, exp);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         buf_size = '0;
         rearm();
         header_events_due.delete();
      end else begin
         // A result shows no earlier than the cycle after its byte, so retire before predicting.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (header_events_due.size() == 0) begin
               report("result with no expectation", 32'(rsp_mon.result_kind), '0);
            end else begin
               want = header_events_due.pop_front();
               check_field("result_kind", 32'(rsp_mon.result_kind), 32'(want.kind));
               check_field("str_offset", rsp_mon.str_offset, want.str_offset);
               check_field("str_length", 32'(rsp_mon.str_length), 32'(want.str_length));
               check_field("stream_size", rsp_mon.stream_size, want.bit_length);
               check_field("header_size", rsp_mon.header_size, want.hdr_length);
               check_field("magic_size", 32'(rsp_mon.magic_size), 32'(want.magic_len));
               check_field("error_code", 32'(rsp_mon.error_code), 32'(want.err));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (predict_byte(req_mon.data_byte, seen_ev)) header_events_due.push_back(seen_ev);
         end
         // A register write only counts from the next byte on, as in the parser.
         if (csr_wr_en) buf_size = csr_wr_data;
      end
      pending_count <= header_events_due.size();
      error_count   <= mismatches;
   end

endmodule

>>> tb/tb_top.sv
// Top of the bit file header parser testbench: clock, reset, stimulus and verdict.
// Depends on fbhp_pkg, the two channel interfaces, the parser and fbhp_checker.
module tb_top;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   int          pending_count;
   int          error_count;

   fbhp_req_if req_if();
   fbhp_rsp_if rsp_if();

   // While set, the sender offers a byte on every cycle without gaps.
   bit          sender_calm;
   int          items_sent;
   // The header currently being built, in file order.
   logic [7:0]  frame[$];

   fpga_bitfile_header_parser u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // The checker sees every transaction on both channels and every register
   // write; it reports how many results are still due and how many checks failed.
   fbhp_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .pending_count (pending_count),
      .error_count   (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: far beyond the slowest correct run, including the long hold-offs.
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   // Receiver. It refuses about a quarter of the cycles at random, accepts on
   // every cycle through one long window, and twice holds ready low in a
   // hold-off. As the parser has a single result register, a hold-off soon
   // backs up into the request channel while the sender keeps offering bytes.
   initial begin : receiver
      int cycle;
      int hold;
      cycle = 0;
      hold  = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cycle++;
         if (cycle == 1500 || cycle == 3500) hold = 250;
         if (hold > 0) begin
            hold--;
            rsp_if.ready <= 1'b0;
         end else if (cycle >= 700 && cycle < 1200) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= 25);
         end
      end
   end

   // Offers one byte, after a random gap unless the sender is calm, and
   // returns at the edge where the transaction is taken. Valid stays high on
   // return, so back-to-back bytes never lower and raise it in one step.
   task automatic send_byte(input logic [7:0] b);
      if (!sender_calm)
         while ($urandom_range(99) < 25) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_frame();
      foreach (frame[i]) send_byte(frame[i]);
   endtask

   // The buffer size may only change while the parser is idle: the sender
   // stops, waits until every predicted result has been taken, then lets a
   // few more cycles pass, as a text byte may still be settling in the parser.
   task automatic write_buffer_size(input logic [31:0] value);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Builds a well-formed header: magic length, the alternating magic pattern
   // (its parity follows the byte offset, which starts at two), the zero byte,
   // the half word one, strings a to d with random text ending in NUL, then
   // tag e and a random bitstream length.
   task automatic make_header(input int mlen, input int max_slen);
      int          slen;
      logic [31:0] blen;
      frame.delete();
      frame.push_back(mlen[15:8]);
      frame.push_back(mlen[7:0]);
      for (int i = 2; i <= mlen; i++)
         frame.push_back(i % 2 == 0 ? fbhp_pkg::MAGIC_EVEN : fbhp_pkg::MAGIC_ODD);
      frame.push_back(8'h00);
      frame.push_back(fbhp_pkg::HALF_WORD_ONE[15:8]);
      frame.push_back(fbhp_pkg::HALF_WORD_ONE[7:0]);
      for (int s = 0; s < 4; s++) begin
         slen = $urandom_range(max_slen);
         frame.push_back(fbhp_pkg::TAG_A + 8'(s));
         frame.push_back(slen[15:8]);
         frame.push_back(slen[7:0]);
         for (int j = 1; j < slen; j++) frame.push_back(8'($urandom_range(255)));
         if (slen > 0) frame.push_back(8'h00);
      end
      frame.push_back(fbhp_pkg::TAG_E);
      blen = $urandom;
      for (int j = 3; j >= 0; j--) frame.push_back(blen[8*j +: 8]);
   endtask

   initial begin : stimulus
      int          pick;
      int          pos;
      logic [31:0] buf_bytes;
      req_if.valid     <= 1'b0;
      req_if.data_byte <= 8'h00;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= 32'd0;
      reset            <= 1'b1;
      sender_calm = 1'b0;
      items_sent  = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The buffer size is zero out of reset, so the first
      // byte is refused as too small; a size of one is refused likewise.
      // Then a minimal header under the largest size: magic length one (no
      // magic bytes) and four empty strings, each reported straight after its
      // length bytes.
      send_byte(8'h00);
      write_buffer_size(32'd1);
      send_byte(8'hff);
      write_buffer_size(32'hffff_ffff);
      make_header(1, 0);
      send_frame();

      // Random part. Each round picks a buffer size: tiny sizes that fail
      // on the first bytes, tight sizes that make the bounds checks bite at
      // every stage, and the largest or random large sizes that let whole
      // headers through. Some headers carry one corrupted byte and some are
      // followed by noise, which the parser takes as the start of a new header.
      for (int p = 0; items_sent < 1650; p++) begin
         pick = $urandom_range(99);
         if (pick < 15) buf_bytes = $urandom_range(4);
         else if (pick < 50) buf_bytes = $urandom_range(90, 20);
         else if (pick < 80) buf_bytes = 32'hffff_ffff;
         else buf_bytes = $urandom;
         write_buffer_size(buf_bytes);
         sender_calm = (p == 4 || p == 5);
         if (buf_bytes < 5) begin
            repeat (8) send_byte(8'($urandom));
            continue;
         end
         repeat ($urandom_range(6, 2)) begin
            if ($urandom_range(99) < 8)
               make_header($urandom_range(200, 64), 12);
            else
               make_header($urandom_range(16), ($urandom_range(9) == 0) ? 40 : 10);
            if ($urandom_range(99) < 20) begin
               pos = $urandom_range(frame.size() - 1);
               frame[pos] = 8'($urandom);
            end
            send_frame();
            if ($urandom_range(99) < 8)
               repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
         end
      end
      sender_calm = 1'b0;

      // Drain: every predicted result must arrive, then a short settling time
      // catches any result the parser gives without a matching prediction.
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sim.f
rtl/fbhp_pkg.sv
rtl/fbhp_req_if.sv
rtl/fbhp_rsp_if.sv
rtl/fpga_bitfile_header_parser.sv
tb/fbhp_checker.sv
tb/tb_top.sv
